@@ design/rse_pkg.sv @@
// shared constants, codes and types of the reverse polish stack evaluator
package rse_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // payload widths
    localparam int DATA_W      = 32;
    localparam int ACT_W       = 2;
    localparam int DIGIT_W     = 4;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END  = 2'd2;

    // operator codes
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DIV0  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVF   = 3'd4;

    // per-cell shift command
    typedef logic [1:0] t_cell_cmd;
    localparam t_cell_cmd CELL_HOLD = 2'd0;
    localparam t_cell_cmd CELL_PUSH = 2'd1;
    localparam t_cell_cmd CELL_POP  = 2'd2;

    typedef logic [DATA_W-1:0] t_word;

endpackage

@@ design/rse_in_if.sv @@
// token channel: valid/ready handshake with action, digit and operator
interface rse_in_if;
    import rse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [DIGIT_W-1:0]   digit;
    logic [OP_W-1:0]      op_code;

    modport source (output valid, output action, output digit, output op_code, input ready);
    modport sink   (input valid, input action, input digit, input op_code, output ready);
endinterface

@@ design/rse_out_if.sv @@
// result channel: valid/ready handshake with value and status
interface rse_out_if;
    import rse_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   value;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

@@ design/rpn_stack_evaluator.sv @@
// top level: reverse polish evaluator built on a shifting chain of stack cells
//
//  channel  | dir | handshake     | word contents
//  ---------+-----+---------------+-------------------------------------------
//  i_tok    | in  | valid / ready | action[1:0], digit[3:0], op_code[1:0]
//  o_res    | out | valid / ready | value[31:0] signed, status[2:0]
//
//  push, add, subtract, multiply and end words are handled directly from the idle state
//  a divide is accepted, runs 32 shift-subtract steps in rse_div,
//  then writes the quotient back to the top of the stack
//  i_rst_n is synchronous: state, count, error and result valid clear, cell contents stay undefined
//  every word waits while a divide runs; an end word also waits when the result register is full and not being taken;
//  other words are accepted while a result waits
module rpn_stack_evaluator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rse_in_if.sink    i_tok,
    rse_out_if.source o_res
);
    import rse_pkg::*;

    // sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic                   r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [STATUS_W-1:0]    r_err, n_err;

    logic                   r_out_valid;
    t_word                  r_out_value;
    logic [STATUS_W-1:0]    r_out_status;

    logic                   w_tok_acc;
    logic                   w_end_acc;
    logic                   w_do_push;
    logic                   w_do_pop;
    logic                   w_top_load;
    logic                   w_div_start;
    logic                   w_div_done;
    t_word                  w_quot;
    t_word                  w_alu;
    t_word                  w_top_val;

    // cell chain taps: cell 0 is top of stack
    t_word                  w_cell [STACK_DEPTH];
    t_word                  w_up   [STACK_DEPTH];
    t_word                  w_down [STACK_DEPTH];
    t_cell_cmd              w_cmd  [STACK_DEPTH];

    // an end word needs a free result slot, everything else only an idle sequencer
    assign i_tok.ready = (r_state == S_IDLE) &&
                         ((i_tok.action != ACT_END) || !r_out_valid || o_res.ready);
    assign w_tok_acc   = i_tok.valid && i_tok.ready;
    assign w_end_acc   = w_tok_acc && (i_tok.action == ACT_END);

    // combinational operators; left operand is the word below the top
    always_comb begin
        case (i_tok.op_code)
            OP_ADD:  w_alu = w_cell[1] + w_cell[0];
            OP_SUB:  w_alu = w_cell[1] - w_cell[0];
            OP_MUL:  w_alu = w_cell[1] * w_cell[0];
            default: w_alu = w_cell[1];
        endcase
    end

    // token decode and stack bookkeeping
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        w_do_push   = 1'b0;
        w_do_pop    = 1'b0;
        w_top_load  = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_tok_acc) begin
                    case (i_tok.action)
                        ACT_PUSH: begin
                            if (r_err == ST_OK) begin
                                if (r_count == CNT_W'(STACK_DEPTH)) begin
                                    n_err = ST_OVF;
                                end else begin
                                    w_do_push = 1'b1;
                                    n_count   = r_count + 1'b1;
                                end
                            end
                        end
                        ACT_OP: begin
                            if (r_err == ST_OK) begin
                                if (r_count < CNT_W'(2)) begin
                                    n_err = ST_FEW;
                                end else if (i_tok.op_code == OP_DIV) begin
                                    if (w_cell[0] == '0) begin
                                        n_err = ST_DIV0;
                                    end else begin
                                        w_div_start = 1'b1;
                                        n_state     = S_DIV;
                                    end
                                end else begin
                                    w_top_load = 1'b1;
                                    w_do_pop   = 1'b1;
                                    n_count    = r_count - 1'b1;
                                end
                            end
                        end
                        ACT_END: begin
                            n_count = '0;
                            n_err   = ST_OK;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                // stack is frozen until the quotient comes back
                if (w_div_done) begin
                    w_top_load = 1'b1;
                    w_do_pop   = 1'b1;
                    n_count    = r_count - 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // value entering the top cell
    always_comb begin
        if (w_do_push) begin
            w_top_val = t_word'(i_tok.digit);
        end else if (r_state == S_DIV) begin
            w_top_val = w_quot;
        end else begin
            w_top_val = w_alu;
        end
    end

    // chain wiring: push shifts down, pop shifts up, top cell loads new words
    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_top
                assign w_up[gi]  = w_top_val;
                assign w_cmd[gi] = (w_do_push || w_top_load) ? CELL_PUSH : CELL_HOLD;
            end else begin : g_body
                assign w_up[gi]  = w_cell[gi-1];
                assign w_cmd[gi] = w_do_push ? CELL_PUSH :
                                   w_do_pop  ? CELL_POP  : CELL_HOLD;
            end
            if (gi == STACK_DEPTH - 1) begin : g_bot
                assign w_down[gi] = '0;
            end else begin : g_mid
                assign w_down[gi] = w_cell[gi+1];
            end

            rse_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd[gi]),
                .i_from_up   (w_up[gi]),
                .i_from_down (w_down[gi]),
                .o_value     (w_cell[gi])
            );
        end
    endgenerate

    // shared divider, left operand over top of stack
    rse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_cell[1]),
        .i_divisor  (w_cell[0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_err   <= ST_OK;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_end_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end_acc) begin
            if (r_err != ST_OK) begin
                r_out_value  <= '0;
                r_out_status <= r_err;
            end else if (r_count != CNT_W'(1)) begin
                r_out_value  <= '0;
                r_out_status <= ST_COUNT;
            end else begin
                r_out_value  <= w_cell[0];
                r_out_status <= ST_OK;
            end
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_out_value;
    assign o_res.status = r_out_status;

`ifndef SYNTHESIS
    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !i_tok.ready)
        else $error("token accepted during divide");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("quotient returned outside divide");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_acc |=> (o_res.valid && (r_count == '0) && (r_err == ST_OK)))
        else $error("end word did not post result and clear");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_push |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not advance count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err == ST_OK) |-> (r_count <= CNT_W'(STACK_DEPTH)))
        else $error("stack count beyond depth");
`endif
endmodule

@@ design/rse_cell.sv @@
// one stack cell: holds a word, takes it from the neighbor above or below
module rse_cell (
    input  logic                i_clk,
    input  rse_pkg::t_cell_cmd  i_cmd,
    input  rse_pkg::t_word      i_from_up,
    input  rse_pkg::t_word      i_from_down,
    output rse_pkg::t_word      o_value
);
    import rse_pkg::*;

    t_word r_value;

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CELL_PUSH: r_value <= i_from_up;
            CELL_POP:  r_value <= i_from_down;
            default:   r_value <= r_value;
        endcase
    end

    assign o_value = r_value;
endmodule

@@ design/rse_div.sv @@
// iterative signed divider, one quotient bit per cycle, truncates toward zero
module rse_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rse_pkg::t_word  i_dividend,
    input  rse_pkg::t_word  i_divisor,
    output logic            o_done,
    output rse_pkg::t_word  o_quot
);
    import rse_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    t_word                  r_rem;
    t_word                  r_quo;
    t_word                  r_den;
    logic                   r_neg;

    logic [DATA_W:0]        w_sh;
    logic [DATA_W:0]        w_diff;
    logic                   w_fit;

    assign w_sh   = {r_rem, r_quo[DATA_W-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_fit  = !w_diff[DATA_W];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: magnitudes at start, then shift-subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_W-1] ? (t_word'(0) - i_dividend) : i_dividend;
            r_den <= i_divisor[DATA_W-1]  ? (t_word'(0) - i_divisor)  : i_divisor;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DATA_W-1:0] : w_sh[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (t_word'(0) - r_quo) : r_quo;
endmodule

@@ sim/rpn_stack_evaluator_tb.sv @@
// testbench of rpn_stack_evaluator: random and directed token streams checked against a predictor
module rpn_stack_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rse_pkg::*;

    localparam int QUIET_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int TAIL_CYCLES = 40;     // tail after the last result is drained, longer than a divide
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off

    // action code that the block ignores
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [DIGIT_W-1:0] digit;
        logic [OP_W-1:0]    op_code;
    } token_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
    } result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rse_in_if  tok_if ();
    rse_out_if res_if ();

    rpn_stack_evaluator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [DATA_W-1:0]   calc_stack [STACK_DEPTH];
    int                  calc_depth;
    logic [STATUS_W-1:0] calc_error;
    result_t             pending_results [$];

    int  mismatches  = 0;
    int  tokens_sent = 0;
    bit  no_idle     = 1'b0;
    int  hold_req    = 0;
    int  quiet_count = 0;

    function automatic logic [DATA_W-1:0] signed_quotient(input logic [DATA_W-1:0] l,
                                                          input logic [DATA_W-1:0] r);
        logic [DATA_W-1:0] ml;
        logic [DATA_W-1:0] mr;
        logic [DATA_W-1:0] q;
        ml = l[DATA_W-1] ? -l : l;
        mr = r[DATA_W-1] ? -r : r;
        q  = ml / mr;
        return (l[DATA_W-1] != r[DATA_W-1]) ? -q : q;
    endfunction

    function automatic logic [DATA_W-1:0] apply_operator(input logic [OP_W-1:0] op,
                                                         input logic [DATA_W-1:0] l,
                                                         input logic [DATA_W-1:0] r);
        case (op)
            OP_ADD:  return l + r;
            OP_SUB:  return l - r;
            OP_MUL:  return l * r;
            default: return signed_quotient(l, r);
        endcase
    endfunction

    // advance the predictor by one accepted word, queue the result of an end word
    task automatic evaluate_token(input token_t t);
        logic [DATA_W-1:0] l;
        logic [DATA_W-1:0] r;
        result_t           res;
        case (t.action)
            ACT_PUSH: begin
                if (calc_error == ST_OK) begin
                    if (calc_depth >= STACK_DEPTH) begin
                        calc_error = ST_OVF;
                    end else begin
                        calc_stack[calc_depth] = DATA_W'(t.digit);
                        calc_depth++;
                    end
                end
            end
            ACT_OP: begin
                if (calc_error == ST_OK) begin
                    if (calc_depth < 2) begin
                        calc_error = ST_FEW;
                    end else begin
                        r = calc_stack[calc_depth-1];
                        l = calc_stack[calc_depth-2];
                        if (t.op_code == OP_DIV && r == '0) begin
                            calc_error = ST_DIV0;
                        end else begin
                            calc_stack[calc_depth-2] = apply_operator(t.op_code, l, r);
                            calc_depth--;
                        end
                    end
                end
            end
            ACT_END: begin
                res.value = '0;
                if (calc_error != ST_OK) begin
                    res.status = calc_error;
                end else if (calc_depth != 1) begin
                    res.status = ST_COUNT;
                end else begin
                    res.status = ST_OK;
                    res.value  = calc_stack[0];
                end
                pending_results.push_back(res);
                calc_depth = 0;
                calc_error = ST_OK;
            end
            default: ;  // unused action code is dropped
        endcase
    endtask

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 32);
    endfunction

    // offer one word, wait for it to be taken, then predict
    task automatic send_token(input token_t t);
        int gap;
        gap = 0;
        while (idle_now()) gap++;
        if (gap > 0) begin
            tok_if.valid   <= 1'b0;
            tok_if.action  <= ACT_W'($urandom);
            tok_if.digit   <= DIGIT_W'($urandom);
            tok_if.op_code <= OP_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        tok_if.valid   <= 1'b1;
        tok_if.action  <= t.action;
        tok_if.digit   <= t.digit;
        tok_if.op_code <= t.op_code;
        @(posedge i_clk);
        while (!tok_if.ready) @(posedge i_clk);
        evaluate_token(t);
        if (t.action != ACT_NONE) tokens_sent++;
    endtask

    // word of the given action, unused fields random
    function automatic token_t make_token(input logic [ACT_W-1:0] act,
                                          input logic [DIGIT_W-1:0] dig,
                                          input logic [OP_W-1:0] op);
        token_t t;
        t.action  = act;
        t.digit   = (act == ACT_PUSH) ? dig : DIGIT_W'($urandom);
        t.op_code = (act == ACT_OP) ? op : OP_W'($urandom);
        return t;
    endfunction

    task automatic push_digit(input logic [DIGIT_W-1:0] d);
        send_token(make_token(ACT_PUSH, d, OP_ADD));
    endtask

    task automatic apply_op(input logic [OP_W-1:0] op);
        send_token(make_token(ACT_OP, '0, op));
    endtask

    task automatic end_expr();
        send_token(make_token(ACT_END, '0, OP_ADD));
    endtask

    function automatic logic [DIGIT_W-1:0] rand_digit();
        if ($urandom_range(0, 99) < 15) return DIGIT_W'($urandom_range(0, 15));
        return DIGIT_W'($urandom_range(0, 9));
    endfunction

    // well-formed expression with n_vals operands and random content
    task automatic send_expression(input int n_vals);
        int depth;
        int pushed;
        depth  = 0;
        pushed = 0;
        while (pushed < n_vals || depth > 1) begin
            if (depth < 2 || (pushed < n_vals && $urandom_range(0, 1) == 1)) begin
                push_digit(rand_digit());
                pushed++;
                depth++;
            end else begin
                apply_op(OP_W'($urandom));
                depth--;
            end
        end
        end_expr();
    endtask

    // arbitrary words, sometimes closed by an end word
    task automatic send_noise();
        int len;
        token_t t;
        len = $urandom_range(1, 12);
        repeat (len) begin
            t = token_t'($urandom);
            send_token(t);
        end
        if ($urandom_range(0, 99) < 70) end_expr();
    endtask

    task automatic send_random_expression();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            send_noise();
        end else if (pick < 75) begin
            send_expression($urandom_range(1, 5));
        end else if (pick < 96) begin
            send_expression($urandom_range(6, 16));
        end else begin
            send_expression($urandom_range(17, 19));
        end
    endtask

    // stop offering and wait for every queued result
    task automatic drain_results();
        tok_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_directed();
        push_digit(4'd9); push_digit(4'd0); apply_op(OP_SUB); end_expr();
        push_digit(4'd9); push_digit(4'd9); apply_op(OP_ADD); end_expr();
        // divide by zero, then a push that the sticky error swallows
        push_digit(4'd0); push_digit(4'd0); apply_op(OP_DIV); push_digit(4'd5); end_expr();
        // operator on an empty stack
        apply_op(OP_ADD); end_expr();
        // end with nothing on the stack
        end_expr();
        // digit above nine
        push_digit(4'd15); push_digit(4'd3); apply_op(OP_MUL); end_expr();
        // unused action code in the middle of an expression
        push_digit(4'd7);
        send_token(make_token(ACT_NONE, DIGIT_W'($urandom), OP_W'($urandom)));
        push_digit(4'd2); apply_op(OP_DIV); end_expr();
    endtask

    task automatic test_stack_limit();
        // exactly full stack, folded back down
        repeat (STACK_DEPTH) push_digit(rand_digit());
        repeat (STACK_DEPTH - 1) apply_op(OP_W'($urandom_range(0, 2)));
        end_expr();
        // one push past full
        repeat (STACK_DEPTH + 1) push_digit(rand_digit());
        apply_op(OP_ADD);
        end_expr();
    endtask

    task automatic test_most_negative_divide();
        // 8^10 * 2 wraps to the most negative value
        repeat (10) push_digit(4'd8);
        repeat (9) apply_op(OP_MUL);
        push_digit(4'd2); apply_op(OP_MUL);
        push_digit(4'd0); push_digit(4'd1); apply_op(OP_SUB);
        apply_op(OP_DIV);
        end_expr();
    endtask

    task automatic test_backpressure();
        hold_req = HOLD_CYCLES;
        repeat (8) send_expression($urandom_range(1, 4));
        drain_results();
    endtask

    task automatic test_no_idle();
        int stop_at;
        stop_at = tokens_sent + 200;
        no_idle = 1'b1;
        while (tokens_sent < stop_at) send_random_expression();
        no_idle = 1'b0;
    endtask

    task automatic test_random(input int target);
        while (tokens_sent < target) begin
            send_random_expression();
            if ($urandom_range(0, 99) < 3) drain_results();
        end
    endtask

    // result side: check each taken word, then drive ready for the next edge
    initial begin
        result_t want;
        int      hold_left;
        hold_left    = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d", $time,
                             res_if.value, res_if.status);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_if.value !== want.value) begin
                        $display("%0t: value expected %0d got %0d", $time,
                                 want.value, res_if.value);
                        mismatches++;
                    end
                    if (res_if.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, res_if.status);
                        mismatches++;
                    end
                end
            end
            if (hold_left == 0 && hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !idle_now();
            end
        end
    end

    // watchdog on a stalled handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((tok_if.valid && tok_if.ready) || (res_if.valid && res_if.ready)) begin
                quiet_count <= 0;
            end else if (quiet_count >= QUIET_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    initial begin
        calc_depth     = 0;
        calc_error     = ST_OK;
        i_rst_n        <= 1'b0;
        tok_if.valid   <= 1'b0;
        tok_if.action  <= ACT_PUSH;
        tok_if.digit   <= '0;
        tok_if.op_code <= OP_ADD;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        drain_results();
        test_stack_limit();
        test_most_negative_divide();
        drain_results();
        test_backpressure();
        test_no_idle();
        test_random(1300);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/rse_pkg.sv
design/rse_in_if.sv
design/rse_out_if.sv
design/rse_cell.sv
design/rse_div.sv
design/rpn_stack_evaluator.sv
sim/rpn_stack_evaluator_tb.sv
